@@ sv/assert_macros.svh @@
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("implication check failed");

// Implication checked on the next clock, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("next-cycle check failed");

// Check that is not masked by reset.
`define ASSERT_ALWAYS(label, clk, pre, post) \
   label: assert property (@(posedge clk) (pre) |-> (post)) \
      else $error("unconditional check failed");

`endif

@@ sv/rd_pkg.sv @@
`timescale 1ns / 1ps
package rd_pkg;

   localparam int FRAC_BITS = 14;
   localparam int NUM_STAGES = 16;
   localparam int SQRT_FIRST = 7;
   localparam int SQRT_LAST = 13;
   localparam int SQRT_PER_STAGE = 3;
   localparam int RAD_W = 2 * FRAC_BITS + 14;
   localparam int ROOT_W = RAD_W / 2;
   localparam int DIR_W = 20;

   // Operands that ride alongside the main datapath.
   typedef struct packed {
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      logic signed [15:0] nz;
      logic signed [32:0] erx;
      logic signed [32:0] ery;
      logic signed [32:0] erz;
      logic [15:0]        r;
   } side_type;

endpackage

@@ sv/refraction_direction.sv @@
`timescale 1ns / 1ps
// Refracted ray direction by Snell's law, fully pipelined.
// Each accepted request leaves its result on the rsp_ port.
// Throughput: one request per cycle; the whole pipeline holds when a result waits.
// The square root is a 7-stage digit pipeline, the longest single part of the 16 stages.
// Reset (synchronous, active high) clears all valid bits; data registers are not reset.
module refraction_direction (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic signed [15:0]     req_eye_x,
   input  logic signed [15:0]     req_eye_y,
   input  logic signed [15:0]     req_eye_z,
   input  logic signed [15:0]     req_normal_x,
   input  logic signed [15:0]     req_normal_y,
   input  logic signed [15:0]     req_normal_z,
   input  logic [15:0]            req_index_ratio,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic signed [19:0]     rsp_dir_x,
   output logic signed [19:0]     rsp_dir_y,
   output logic signed [19:0]     rsp_dir_z,
   output logic                   rsp_total_internal
);
   import rd_pkg::*;

   // Global advance: every stage moves when the output register is empty or
   // being drained. Bubbles travel along with their valid bits.
   logic en;
   logic v_ff [1:NUM_STAGES];

   // Side operands: normal, eye times ratio, and the ratio itself.
   side_type side_in;
   side_type side_ff [1:15];

   // Stage 1 products.
   logic signed [31:0] dp_in [3];
   logic signed [31:0] dp_ff [3];
   logic [31:0]        rr_in, rr_ff;

   // Stage 2: cos_i and ratio squared.
   logic signed [32:0] dot;
   logic signed [33:0] dot_rnd;
   logic [32:0]        rr_rnd;
   logic signed [18:0] ci_in, ci_ff;
   logic [20:0]        r2_in, r2_ff [2:4];

   // Stage 3: cos_i squared and ratio times cos_i.
   logic signed [37:0] cc_in, cc_ff;
   logic signed [35:0] rci_in, rci_ff;

   // Stage 4: one minus cos_i squared, and the rounded ratio times cos_i.
   logic signed [39:0] om_tmp;
   logic signed [36:0] rc_tmp;
   logic signed [22:0] om_in, om_ff;
   logic signed [21:0] rc_in, rc_ff [4:13];

   // Stage 5: sin2_t before rounding.
   logic signed [44:0] pr_in, pr_ff;

   // Stage 6: rounding, the total internal reflection test and the radicand.
   logic signed [45:0] s2_tmp;
   logic signed [30:0] s2;
   logic signed [31:0] d_val;
   logic               tir_in;
   logic               tir_ff [6:15];
   logic [RAD_W-1:0]   rad_in, rad_ff;

   // Square root stages, three result bits per stage.
   logic [RAD_W:0] rem_in [SQRT_FIRST:SQRT_LAST];
   logic [RAD_W:0] res_in [SQRT_FIRST:SQRT_LAST];
   logic [RAD_W:0] rem_ff [SQRT_FIRST:SQRT_LAST];
   logic [RAD_W:0] res_ff [SQRT_FIRST:SQRT_LAST];

   // Stage 14 and 15: the normal's scale and its products.
   logic signed [22:0] k_in, k_ff;
   logic signed [38:0] nk_in [3];
   logic signed [38:0] nk_ff [3];

   // Stage 16: final combine, rounding and saturation.
   logic signed [DIR_W-1:0] dir_in [3];
   logic signed [DIR_W-1:0] dir_ff [3];
   logic                    tir_out_ff;

   assign en        = !v_ff[NUM_STAGES] || rsp_ready;
   assign req_ready = en;

   // Stage 1.
   always_comb begin
      side_in.nx  = req_normal_x;
      side_in.ny  = req_normal_y;
      side_in.nz  = req_normal_z;
      side_in.erx = req_eye_x * $signed({1'b0, req_index_ratio});
      side_in.ery = req_eye_y * $signed({1'b0, req_index_ratio});
      side_in.erz = req_eye_z * $signed({1'b0, req_index_ratio});
      side_in.r   = req_index_ratio;
      dp_in[0]    = req_eye_x * req_normal_x;
      dp_in[1]    = req_eye_y * req_normal_y;
      dp_in[2]    = req_eye_z * req_normal_z;
      rr_in       = req_index_ratio * req_index_ratio;
   end

   // Stage 2: cos_i rounds to FRAC_BITS, ratio squared keeps FRAC_BITS
   // because the ratio carries one fraction bit less.
   always_comb begin
      dot     = 33'(dp_ff[0]) + 33'(dp_ff[1]) + 33'(dp_ff[2]);
      dot_rnd = 34'(dot) + 34'sd8192;
      ci_in   = dot_rnd[32:14];
      rr_rnd  = {1'b0, rr_ff} + 33'd2048;
      r2_in   = rr_rnd[32:12];
   end

   // Stage 3.
   always_comb begin
      cc_in  = ci_ff * ci_ff;
      rci_in = $signed({1'b0, side_ff[2].r}) * ci_ff;
   end

   // Stage 4.
   always_comb begin
      om_tmp = 40'sd268443648 - 40'(cc_ff);
      om_in  = om_tmp[36:14];
      rc_tmp = 37'(rci_ff) + 37'sd4096;
      rc_in  = rc_tmp[34:13];
   end

   // Stage 5.
   assign pr_in = $signed({1'b0, r2_ff[4]}) * om_ff;

   // Stage 6. Only the total reflection case lets sin2_t exceed one, so the
   // radicand is nonnegative whenever it is used.
   always_comb begin
      s2_tmp = 46'(pr_ff) + 46'sd8192;
      s2     = s2_tmp[44:14];
      tir_in = s2 > 31'sd16384;
      d_val  = 32'sd16384 - 32'(s2);
      rad_in = tir_in ? '0 : {d_val[27:0], {FRAC_BITS{1'b0}}};
   end

   // Restoring square root, bit pair by bit pair from the top.
   always_comb begin
      logic [RAD_W:0] rem_v;
      logic [RAD_W:0] res_v;
      logic [RAD_W:0] bit_v;
      for (int s = SQRT_FIRST; s <= SQRT_LAST; s++) begin
         if (s == SQRT_FIRST) begin
            rem_v = {1'b0, rad_ff};
            res_v = '0;
         end else begin
            rem_v = rem_ff[s-1];
            res_v = res_ff[s-1];
         end
         for (int t = 0; t < SQRT_PER_STAGE; t++) begin
            bit_v = (RAD_W+1)'(1) << (RAD_W - 2 - 2 * ((s - SQRT_FIRST) * SQRT_PER_STAGE + t));
            if (rem_v >= res_v + bit_v) begin
               rem_v = rem_v - (res_v + bit_v);
               res_v = (res_v >> 1) + bit_v;
            end else begin
               res_v = res_v >> 1;
            end
         end
         rem_in[s] = rem_v;
         res_in[s] = res_v;
      end
   end

   // Stage 14: k = ratio*cos_i - cos_t.
   assign k_in = 23'(rc_ff[13]) - $signed({2'b00, res_ff[SQRT_LAST][ROOT_W-1:0]});

   // Stage 15.
   always_comb begin
      nk_in[0] = side_ff[14].nx * k_ff;
      nk_in[1] = side_ff[14].ny * k_ff;
      nk_in[2] = side_ff[14].nz * k_ff;
   end

   // Stage 16: N*k - E*r with one rounding, then saturation to Q5.14.
   always_comb begin
      logic signed [32:0] er_v [3];
      logic signed [39:0] acc;
      logic signed [25:0] sh;
      er_v[0] = side_ff[15].erx;
      er_v[1] = side_ff[15].ery;
      er_v[2] = side_ff[15].erz;
      for (int i = 0; i < 3; i++) begin
         acc = 40'(nk_ff[i]) - (40'(er_v[i]) <<< 1) + 40'sd8192;
         sh  = acc[39:14];
         if (tir_ff[15]) begin
            dir_in[i] = '0;
         end else if (sh > 26'sd524287) begin
            dir_in[i] = 20'sd524287;
         end else if (sh < -26'sd524288) begin
            dir_in[i] = -20'sd524288;
         end else begin
            dir_in[i] = sh[19:0];
         end
      end
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i <= NUM_STAGES; i++) v_ff[i] <= 1'b0;
      end else if (en) begin
         v_ff[1] <= req_valid;
         for (int i = 2; i <= NUM_STAGES; i++) v_ff[i] <= v_ff[i-1];
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[1] <= side_in;
         for (int i = 2; i <= 15; i++) side_ff[i] <= side_ff[i-1];
         for (int i = 0; i < 3; i++) dp_ff[i] <= dp_in[i];
         rr_ff    <= rr_in;
         ci_ff    <= ci_in;
         r2_ff[2] <= r2_in;
         r2_ff[3] <= r2_ff[2];
         r2_ff[4] <= r2_ff[3];
         cc_ff    <= cc_in;
         rci_ff   <= rci_in;
         om_ff    <= om_in;
         rc_ff[4] <= rc_in;
         for (int i = 5; i <= 13; i++) rc_ff[i] <= rc_ff[i-1];
         pr_ff    <= pr_in;
         tir_ff[6] <= tir_in;
         for (int i = 7; i <= 15; i++) tir_ff[i] <= tir_ff[i-1];
         rad_ff   <= rad_in;
         for (int s = SQRT_FIRST; s <= SQRT_LAST; s++) begin
            rem_ff[s] <= rem_in[s];
            res_ff[s] <= res_in[s];
         end
         k_ff <= k_in;
         for (int i = 0; i < 3; i++) begin
            nk_ff[i]  <= nk_in[i];
            dir_ff[i] <= dir_in[i];
         end
         tir_out_ff <= tir_ff[15];
      end
   end

   assign rsp_valid          = v_ff[NUM_STAGES];
   assign rsp_dir_x          = dir_ff[0];
   assign rsp_dir_y          = dir_ff[1];
   assign rsp_dir_z          = dir_ff[2];
   assign rsp_total_internal = tir_out_ff;

endmodule

@@ sv/rd_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rd_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [19:0] rsp_dir_x,
   input logic signed [19:0] rsp_dir_y,
   input logic signed [19:0] rsp_dir_z,
   input logic               rsp_total_internal
);

   // A flagged total reflection carries a zero direction.
   `ASSERT_IMPLY(a_tir_zero, clock, reset, rsp_valid && rsp_total_internal, rsp_dir_x == 20'sd0 && rsp_dir_y == 20'sd0 && rsp_dir_z == 20'sd0)

   // With the output stage empty the pipeline always takes a new request.
   `ASSERT_IMPLY(a_ready_when_empty, clock, reset, !rsp_valid, req_ready)

   // A stalled result stays put.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_dir_x) && $stable(rsp_total_internal))

   // Reset empties the pipeline.
   `ASSERT_ALWAYS(a_reset_empty, clock, $past(reset), !rsp_valid)

endmodule

bind refraction_direction rd_checker u_rd_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_dir_x          (rsp_dir_x),
   .rsp_dir_y          (rsp_dir_y),
   .rsp_dir_z          (rsp_dir_z),
   .rsp_total_internal (rsp_total_internal)
);
